### rtl/lzced_pkg.sv
// Types, register indices and small helper functions for the LoG zero-crossing edge detector.
// Used by log_zero_cross_edge_detector; no dependencies of its own.
package lzced_pkg;

    localparam int NUM_COEFS   = 6;
    localparam int PIX_W       = 8;
    localparam int COEF_W      = 18;
    localparam int SIZE_W      = 11;
    localparam int ROW_W       = 11;
    localparam int SUM_W       = 11;
    localparam int PROD_W      = COEF_W + SUM_W + 1;
    localparam int MIN_SIZE    = 3;
    localparam int MAX_HEIGHT  = 1024;
    localparam int CFG_IDX_W   = 4;

    typedef logic [PIX_W-1:0]         pix_t;
    typedef logic signed [COEF_W-1:0] coef_t;
    typedef logic [SUM_W-1:0]         csum_t;
    typedef logic signed [PROD_W-1:0] prod_t;

    localparam logic [CFG_IDX_W-1:0] CFG_COEF_D0 = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_D1 = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_D2 = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_D4 = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_D5 = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_D8 = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH   = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT  = 4'd7;

    localparam coef_t COEF_D0_RST = -18'sd8192;
    localparam coef_t COEF_D1_RST = -18'sd2484;
    localparam coef_t COEF_D2_RST = 18'sd0;
    localparam coef_t COEF_D4_RST = 18'sd1109;
    localparam coef_t COEF_D5_RST = 18'sd1009;
    localparam coef_t COEF_D8_RST = 18'sd451;
    localparam logic [SIZE_W-1:0] WIDTH_RST  = 11'd640;
    localparam logic [SIZE_W-1:0] HEIGHT_RST = 11'd480;

    typedef enum logic [1:0] {
        SIGN_ZERO = 2'b00,
        SIGN_POS  = 2'b01,
        SIGN_NEG  = 2'b10
    } sign_t;

    // Per-word bookkeeping that travels down the pipeline beside the data.
    typedef struct packed {
        logic emit;
        logic interior;
        logic frame_end;
    } out_info_t;

    // Weight class of a window tap, from its squared distance to the centre.
    function automatic logic [2:0] dist_class(input int m, input int k);
        int d;
        d = (m - 2) * (m - 2) + (k - 2) * (k - 2);
        case (d)
            0: dist_class = 3'd0;
            1: dist_class = 3'd1;
            2: dist_class = 3'd2;
            4: dist_class = 3'd3;
            5: dist_class = 3'd4;
            default: dist_class = 3'd5;
        endcase
    endfunction

    function automatic logic opposite(input sign_t a, input sign_t b);
        opposite = (a == SIGN_POS && b == SIGN_NEG) || (a == SIGN_NEG && b == SIGN_POS);
    endfunction

endpackage

### rtl/lzced_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module lzced_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/log_zero_cross_edge_detector.sv
// Top level of the LoG zero-crossing edge detector: counters, window pipeline, output stage.
// Depends on lzced_pkg and lzced_ram.
//
// Usage: grey pixels enter on the s_ channel in raster order (s_op = 0), followed by
// pad words (s_op = 1) that push out the last results. Each result word on the m_ channel
// carries 255 where the Laplacian-of-Gaussian response changes sign across the pixel,
// else 0; m_frame_end marks the last pixel of the frame. The result for pixel p is
// produced by the word that is 3*W+3 words later in the frame, and appears on the m_
// channel after that word has passed the pipeline stages and the output register. Pads
// that arrive before all W*H pixels are taken are accepted and dropped.
// Throughput is one word per cycle unless the receiver stalls or a new frame waits: two
// line stores (pixels and response signs) are read and written once per word, and every
// stage holds one word. The first pixel of a frame waits until the pipeline has emptied,
// because it latches the frame size and weights that the stages use.
// Configuration words on cfg_ are accepted in every cycle and take effect at the next
// frame. Reset returns the registers to their defaults and starts a fresh frame; the
// line stores need no clearing. When the receiver stalls, the whole pipeline holds and
// s_ready drops in the same cycle.
module log_zero_cross_edge_detector #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_op,
    input  lzced_pkg::pix_t                  s_pixel,
    output logic                             m_valid,
    input  logic                             m_ready,
    output lzced_pkg::pix_t                  m_edge_mark,
    output logic                             m_frame_end,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [lzced_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lzced_pkg::COEF_W-1:0]     cfg_data
);

    import lzced_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = CW + 1;

    // Configuration and latched frame settings
    coef_t             coef_reg [NUM_COEFS];
    logic [SIZE_W-1:0] frame_width_reg, frame_height_reg;
    coef_t             lat_coef_reg [NUM_COEFS];
    logic [WW-1:0]     lat_w_reg;
    logic [ROW_W-1:0]  lat_h_reg;

    // Input position counters
    logic              in_frame_reg, in_frame_next;
    logic [ROW_W-1:0]  ir_reg, ir_next;
    logic [CW-1:0]     ic_reg, ic_next;

    logic              en, accept, start, take, busy;
    logic [WW-1:0]     sat_w, cur_w;
    logic [ROW_W-1:0]  sat_h, cur_h, cur_ir;
    logic [CW-1:0]     cur_ic, ccol, pc;
    logic signed [ROW_W:0] crow, pr;
    logic              ic_ge2, ic_ge3;
    logic [4:0]        rv0, cv0;
    out_info_t         info0;
    pix_t              pix0;

    // Pipeline stages
    logic              v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg;
    out_info_t         info1_reg, info2_reg, info3_reg, info4_reg, info5_reg, info6_reg;
    out_info_t         info7_reg;
    pix_t              pix1_reg;
    logic [CW-1:0]     ic1_reg;
    logic [CW-1:0]     ccol1_reg, ccol2_reg, ccol3_reg, ccol4_reg, ccol5_reg, ccol6_reg;
    logic [4:0]        rv1_reg, cv1_reg, rv2_reg, cv2_reg;
    pix_t              win_reg [5][5];
    csum_t             sums2 [NUM_COEFS];
    csum_t             sums3_reg [NUM_COEFS];
    prod_t             prod4_reg [NUM_COEFS];
    logic signed [PROD_W:0]   pair5_reg [3];
    logic signed [PROD_W+2:0] total5;
    sign_t             sign5, sign6_reg;
    sign_t             swin_reg [3][3];
    logic              mark7;

    logic [4*PIX_W-1:0] pline_rd, pline_wr;
    logic [3:0]         sline_rd, sline_wr;

    logic              m_valid_reg;
    pix_t              m_edge_mark_reg;
    logic              m_frame_end_reg;

    assign en        = !m_valid_reg || m_ready;
    assign busy      = v1_reg || v2_reg || v3_reg || v4_reg || v5_reg || v6_reg || v7_reg;
    assign s_ready   = en && !(!in_frame_reg && busy);
    assign cfg_ready = 1'b1;
    assign accept    = s_valid && s_ready;
    assign start     = accept && !in_frame_reg && !s_op;
    assign take      = accept && (!s_op || (in_frame_reg && ir_reg >= lat_h_reg));

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg[0]      <= COEF_D0_RST;
            coef_reg[1]      <= COEF_D1_RST;
            coef_reg[2]      <= COEF_D2_RST;
            coef_reg[3]      <= COEF_D4_RST;
            coef_reg[4]      <= COEF_D5_RST;
            coef_reg[5]      <= COEF_D8_RST;
            frame_width_reg  <= WIDTH_RST;
            frame_height_reg <= HEIGHT_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_COEF_D0: coef_reg[0] <= cfg_data;
                CFG_COEF_D1: coef_reg[1] <= cfg_data;
                CFG_COEF_D2: coef_reg[2] <= cfg_data;
                CFG_COEF_D4: coef_reg[3] <= cfg_data;
                CFG_COEF_D5: coef_reg[4] <= cfg_data;
                CFG_COEF_D8: coef_reg[5] <= cfg_data;
                CFG_WIDTH:   frame_width_reg  <= cfg_data[SIZE_W-1:0];
                CFG_HEIGHT:  frame_height_reg <= cfg_data[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (frame_width_reg < SIZE_W'(MIN_SIZE)) begin
            sat_w = WW'(MIN_SIZE);
        end else if (int'(frame_width_reg) > MAX_WIDTH) begin
            sat_w = WW'(MAX_WIDTH);
        end else begin
            sat_w = WW'(frame_width_reg);
        end
        if (frame_height_reg < SIZE_W'(MIN_SIZE)) begin
            sat_h = ROW_W'(MIN_SIZE);
        end else if (int'(frame_height_reg) > MAX_HEIGHT) begin
            sat_h = ROW_W'(MAX_HEIGHT);
        end else begin
            sat_h = frame_height_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lat_w_reg <= WW'(MIN_SIZE);
            lat_h_reg <= ROW_W'(MIN_SIZE);
        end else if (start) begin
            lat_w_reg <= sat_w;
            lat_h_reg <= sat_h;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            lat_coef_reg <= coef_reg;
        end
    end

    // Position of the newest word, the window centre two rows and columns behind it,
    // and the result pixel three rows and columns behind it.
    always_comb begin
        cur_w  = start ? sat_w : lat_w_reg;
        cur_h  = start ? sat_h : lat_h_reg;
        cur_ir = start ? '0 : ir_reg;
        cur_ic = start ? '0 : ic_reg;
        ic_ge2 = cur_ic >= CW'(2);
        ic_ge3 = cur_ic >= CW'(3);
        crow   = $signed({1'b0, cur_ir}) - (ic_ge2 ? (ROW_W+1)'(2) : (ROW_W+1)'(3));
        ccol   = ic_ge2 ? cur_ic - CW'(2) : CW'({1'b0, cur_ic} + cur_w - WW'(2));
        pr     = $signed({1'b0, cur_ir}) - (ic_ge3 ? (ROW_W+1)'(3) : (ROW_W+1)'(4));
        pc     = ic_ge3 ? cur_ic - CW'(3) : CW'({1'b0, cur_ic} + cur_w - WW'(3));
        for (int k = 0; k < 5; k++) begin
            rv0[k] = (crow + (ROW_W+1)'(k) - (ROW_W+1)'(2) >= 0)
                  && (crow + (ROW_W+1)'(k) - (ROW_W+1)'(2) < $signed({1'b0, cur_h}));
            cv0[k] = ($signed({2'b00, ccol}) + (CW+2)'(k) - (CW+2)'(2) >= 0)
                  && ($signed({2'b00, ccol}) + (CW+2)'(k) - (CW+2)'(2)
                      < $signed({1'b0, cur_w}));
        end
        info0.emit      = (cur_ir > ROW_W'(3)) || (cur_ir == ROW_W'(3) && ic_ge3);
        info0.interior  = (pr >= 1) && (pr <= $signed({1'b0, cur_h}) - (ROW_W+1)'(2))
                       && (pc >= CW'(1)) && ({1'b0, pc} <= cur_w - WW'(2));
        info0.frame_end = (cur_ir == cur_h + ROW_W'(3)) && (cur_ic == CW'(2));
        pix0 = (cur_ir < cur_h) ? s_pixel : '0;
    end

    always_comb begin
        in_frame_next = in_frame_reg;
        ir_next       = ir_reg;
        ic_next       = ic_reg;
        if (take) begin
            in_frame_next = !info0.frame_end;
            if ({1'b0, cur_ic} + WW'(1) == cur_w) begin
                ic_next = '0;
                ir_next = cur_ir + ROW_W'(1);
            end else begin
                ic_next = cur_ic + CW'(1);
                ir_next = cur_ir;
            end
            if (info0.frame_end) begin
                ir_next = '0;
                ic_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg <= 1'b0;
            ir_reg       <= '0;
            ic_reg       <= '0;
        end else begin
            in_frame_reg <= in_frame_next;
            ir_reg       <= ir_next;
            ic_reg       <= ic_next;
        end
    end

    // Pixel line store: four rows per column, newest row in the low byte.
    lzced_ram #(.WIDTH(4 * PIX_W), .DEPTH(MAX_WIDTH)) u_pixel_lines (
        .clk     (aclk),
        .wr_en   (en && v1_reg),
        .wr_addr (ic1_reg),
        .wr_data (pline_wr),
        .rd_en   (en),
        .rd_addr (cur_ic),
        .rd_data (pline_rd)
    );
    assign pline_wr = {pline_rd[3*PIX_W-1:0], pix1_reg};

    // Sign line store: two rows of response signs per column.
    lzced_ram #(.WIDTH(4), .DEPTH(MAX_WIDTH)) u_sign_lines (
        .clk     (aclk),
        .wr_en   (en && v6_reg),
        .wr_addr (ccol6_reg),
        .wr_data (sline_wr),
        .rd_en   (en),
        .rd_addr (ccol5_reg),
        .rd_data (sline_rd)
    );
    assign sline_wr = {sline_rd[1:0], sign6_reg};

    // Valid bits of the pipeline
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= take;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
        end
    end

    // Stage 2: sum the masked window pixels of each weight class.
    always_comb begin
        for (int c = 0; c < NUM_COEFS; c++) begin
            sums2[c] = '0;
        end
        for (int m = 0; m < 5; m++) begin
            for (int k = 0; k < 5; k++) begin
                if (rv2_reg[k] && cv2_reg[m]) begin
                    sums2[dist_class(m, k)] = sums2[dist_class(m, k)] + SUM_W'(win_reg[m][k]);
                end
            end
        end
    end

    always_comb begin
        total5 = (PROD_W+3)'(pair5_reg[0]) + (PROD_W+3)'(pair5_reg[1])
               + (PROD_W+3)'(pair5_reg[2]);
        if (total5 > 0) begin
            sign5 = SIGN_POS;
        end else if (total5 < 0) begin
            sign5 = SIGN_NEG;
        end else begin
            sign5 = SIGN_ZERO;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pix1_reg  <= pix0;
            ic1_reg   <= cur_ic;
            ccol1_reg <= ccol;
            rv1_reg   <= rv0;
            cv1_reg   <= cv0;
            info1_reg <= info0;
            if (v1_reg) begin
                // Window columns run from the oldest (left) to the newest (right).
                for (int m = 0; m < 4; m++) begin
                    win_reg[m] <= win_reg[m+1];
                end
                win_reg[4][4] <= pix1_reg;
                win_reg[4][3] <= pline_rd[PIX_W-1:0];
                win_reg[4][2] <= pline_rd[2*PIX_W-1:PIX_W];
                win_reg[4][1] <= pline_rd[3*PIX_W-1:2*PIX_W];
                win_reg[4][0] <= pline_rd[4*PIX_W-1:3*PIX_W];
            end
            rv2_reg   <= rv1_reg;
            cv2_reg   <= cv1_reg;
            ccol2_reg <= ccol1_reg;
            info2_reg <= info1_reg;
            sums3_reg <= sums2;
            ccol3_reg <= ccol2_reg;
            info3_reg <= info2_reg;
            for (int c = 0; c < NUM_COEFS; c++) begin
                prod4_reg[c] <= prod_t'(lat_coef_reg[c]) * prod_t'($signed({1'b0, sums3_reg[c]}));
            end
            ccol4_reg <= ccol3_reg;
            info4_reg <= info3_reg;
            for (int c = 0; c < 3; c++) begin
                pair5_reg[c] <= (PROD_W+1)'(prod4_reg[2*c]) + (PROD_W+1)'(prod4_reg[2*c+1]);
            end
            ccol5_reg <= ccol4_reg;
            info5_reg <= info4_reg;
            sign6_reg <= sign5;
            ccol6_reg <= ccol5_reg;
            info6_reg <= info5_reg;
            if (v6_reg) begin
                for (int m = 0; m < 2; m++) begin
                    swin_reg[m] <= swin_reg[m+1];
                end
                swin_reg[2][2] <= sign6_reg;
                swin_reg[2][1] <= sign_t'(sline_rd[1:0]);
                swin_reg[2][0] <= sign_t'(sline_rd[3:2]);
            end
            info7_reg <= info6_reg;
        end
    end

    // Stage 7: for an interior pixel, any of the four opposite-neighbour pairs changing sign marks an edge.
    assign mark7 = info7_reg.interior
                && (opposite(swin_reg[1][0], swin_reg[1][2])
                 || opposite(swin_reg[0][1], swin_reg[2][1])
                 || opposite(swin_reg[0][0], swin_reg[2][2])
                 || opposite(swin_reg[2][0], swin_reg[0][2]));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= v7_reg && info7_reg.emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_edge_mark_reg <= mark7 ? 8'hFF : 8'h00;
            m_frame_end_reg <= info7_reg.frame_end;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_edge_mark = m_edge_mark_reg;
    assign m_frame_end = m_frame_end_reg;

    a_mark_levels: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_edge_mark == 8'h00 || m_edge_mark == 8'hFF))
        else $error("edge mark is neither 0 nor 255");

    a_counters_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        in_frame_reg |-> ({1'b0, ic_reg} < lat_w_reg && ir_reg <= lat_h_reg + ROW_W'(3)))
        else $error("input position left the frame");

    a_frame_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && info0.frame_end) |=> (!in_frame_reg && ir_reg == '0 && ic_reg == '0))
        else $error("frame did not close after its last word");

    a_start_on_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy)
        else $error("new frame latched while words are still in flight");

endmodule
